// ===== hw/rtl/tlbp_pkg.sv =====
// Package for the two-level local branch predictor.
// Holds table sizes, counter constants, sequencer codes and the table port structs.
// No dependencies.
package tlbp_pkg;

    // Table geometry
    localparam int HIST_INDEX_BITS = 9;
    localparam int HIST_BITS       = 11;
    localparam int HIST_ENTRIES    = 1 << HIST_INDEX_BITS;
    localparam int PAT_ENTRIES     = 1 << HIST_BITS;
    localparam int CLR_BITS        = (HIST_INDEX_BITS > HIST_BITS) ? HIST_INDEX_BITS : HIST_BITS;

    // Field widths
    localparam int ADDR_BITS  = 32;
    localparam int TOTAL_BITS = 32;
    localparam int CTR_BITS   = 2;

    // Counter constants
    localparam logic [CTR_BITS-1:0] COUNTER_RESET   = 2'd2;
    localparam logic [CTR_BITS-1:0] COUNTER_MAX     = 2'd3;
    localparam logic [CTR_BITS-1:0] COUNTER_MIN     = 2'd0;
    localparam logic [CTR_BITS-1:0] TAKEN_THRESHOLD = 2'd2;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HIST = 2'd1;
    localparam logic [1:0] ST_PAT  = 2'd2;

    typedef logic [HIST_INDEX_BITS-1:0] hidx_t;
    typedef logic [HIST_BITS-1:0]       hist_t;
    typedef logic [CTR_BITS-1:0]        ctr_t;

    // Read and write requests from the sequencer to the tables
    typedef struct packed {
        logic  hist_rd_en;
        hidx_t hist_rd_addr;
        logic  hist_wr_en;
        hidx_t hist_wr_addr;
        hist_t hist_wr_data;
        logic  pat_rd_en;
        hist_t pat_rd_addr;
        logic  pat_wr_en;
        hist_t pat_wr_addr;
        ctr_t  pat_wr_data;
    } tbl_req_t;

    // Read data and status from the tables
    typedef struct packed {
        hist_t hist_rdata;
        ctr_t  pat_rdata;
        logic  clearing;
    } tbl_rsp_t;

endpackage

// ===== hw/rtl/tlbp_tables.sv =====
// History and pattern tables of the branch predictor, with the clearing pass after reset.
// Depends on tlbp_pkg.
module tlbp_tables
(
    input  logic               clk,
    input  logic               rst_n,
    input  tlbp_pkg::tbl_req_t req,
    output tlbp_pkg::tbl_rsp_t rsp
);
    import tlbp_pkg::*;

    hist_t hist_mem [HIST_ENTRIES];
    ctr_t  pat_mem  [PAT_ENTRIES];

    logic                clr_active_reg;
    logic [CLR_BITS-1:0] clr_cnt_reg;
    hist_t               hist_rdata_reg;
    ctr_t                pat_rdata_reg;

    logic  clr_hist_hit;
    logic  clr_pat_hit;
    logic  hist_we;
    hidx_t hist_wa;
    hist_t hist_wd;
    logic  pat_we;
    hist_t pat_wa;
    ctr_t  pat_wd;

    // Decide which entries the sweep covers this cycle
    always_comb
    begin
        clr_hist_hit = (clr_cnt_reg >> HIST_INDEX_BITS) == '0;
        clr_pat_hit  = (clr_cnt_reg >> HIST_BITS) == '0;
    end

    // Select write port source: sweep or sequencer
    always_comb
    begin
        if (clr_active_reg)
        begin
            hist_we = clr_hist_hit;
            hist_wa = clr_cnt_reg[HIST_INDEX_BITS-1:0];
            hist_wd = '0;
            pat_we  = clr_pat_hit;
            pat_wa  = clr_cnt_reg[HIST_BITS-1:0];
            pat_wd  = COUNTER_RESET;
        end
        else
        begin
            hist_we = req.hist_wr_en;
            hist_wa = req.hist_wr_addr;
            hist_wd = req.hist_wr_data;
            pat_we  = req.pat_wr_en;
            pat_wa  = req.pat_wr_addr;
            pat_wd  = req.pat_wr_data;
        end
    end

    // Step the clearing pass: one pattern entry per cycle, history ones while in range
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == '1)
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // History memory
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_wa] <= hist_wd;
        end
        if (req.hist_rd_en)
        begin
            hist_rdata_reg <= hist_mem[req.hist_rd_addr];
        end
    end

    // Pattern counter memory
    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pat_mem[pat_wa] <= pat_wd;
        end
        if (req.pat_rd_en)
        begin
            pat_rdata_reg <= pat_mem[req.pat_rd_addr];
        end
    end

    assign rsp.hist_rdata = hist_rdata_reg;
    assign rsp.pat_rdata  = pat_rdata_reg;
    assign rsp.clearing   = clr_active_reg;

endmodule

// ===== hw/rtl/two_level_local_branch_predictor.sv =====
// Two-level local branch predictor (per-address history, shared pattern table).
// Depends on tlbp_pkg and tlbp_tables.
//
//   channel   handshake                 payload
//   --------  ------------------------  ------------------------------------------
//   branch    start, busy (take: start   branch_address, actual_taken
//             high while busy low)
//   result    done (one-cycle strobe)    predicted_taken, mispredicted,
//                                        correct_total, wrong_total
//
// Each branch runs through the history read, then the pattern counter read that
// the history selects, then the counter update; done rises in the cycle after the
// update, and a new branch may be taken in that same cycle.
// After reset the block clears both tables, with busy held high until the pass ends.
// The receiver cannot stall: each result is shown for exactly one cycle.
module two_level_local_branch_predictor
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [tlbp_pkg::ADDR_BITS-1:0] branch_address,
    input  logic                           actual_taken,
    output logic                           done,
    output logic                           predicted_taken,
    output logic                           mispredicted,
    output logic [tlbp_pkg::TOTAL_BITS-1:0] correct_total,
    output logic [tlbp_pkg::TOTAL_BITS-1:0] wrong_total
);
    import tlbp_pkg::*;

    tbl_req_t tbl_req;
    tbl_rsp_t tbl_rsp;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    hidx_t                 hidx_reg;
    logic                  taken_reg;
    hist_t                 hist_reg;
    logic                  done_reg;
    logic                  pred_reg;
    logic                  miss_reg;
    logic [TOTAL_BITS-1:0] correct_reg;
    logic [TOTAL_BITS-1:0] wrong_reg;

    logic  accept;
    hist_t hist_new;
    ctr_t  ctr;
    ctr_t  ctr_new;
    logic  pred;
    logic  miss;

    tlbp_tables u_tables
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tbl_req),
        .rsp   (tbl_rsp)
    );

    assign busy   = (state_reg != ST_IDLE) || tbl_rsp.clearing;
    assign accept = start && !busy;

    // Shift history right and insert the outcome at the top bit
    assign hist_new = (tbl_rsp.hist_rdata >> 1) | (hist_t'(taken_reg) << (HIST_BITS - 1));

    // Predict and step the counter toward the outcome
    always_comb
    begin
        ctr  = tbl_rsp.pat_rdata;
        pred = ctr >= TAKEN_THRESHOLD;
        miss = pred ^ taken_reg;
        if (taken_reg)
        begin
            ctr_new = (ctr == COUNTER_MAX) ? ctr : ctr + 1'b1;
        end
        else
        begin
            ctr_new = (ctr == COUNTER_MIN) ? ctr : ctr - 1'b1;
        end
    end

    // Sequence table accesses
    always_comb
    begin
        state_next           = state_reg;
        tbl_req              = '0;
        tbl_req.hist_rd_addr = branch_address[HIST_INDEX_BITS+1:2];
        tbl_req.hist_wr_addr = hidx_reg;
        tbl_req.hist_wr_data = hist_new;
        tbl_req.pat_rd_addr  = tbl_rsp.hist_rdata;
        tbl_req.pat_wr_addr  = hist_reg;
        tbl_req.pat_wr_data  = ctr_new;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    tbl_req.hist_rd_en = 1'b1;
                    state_next         = ST_HIST;
                end
            end
            ST_HIST:
            begin
                tbl_req.pat_rd_en  = 1'b1;
                tbl_req.hist_wr_en = 1'b1;
                state_next         = ST_PAT;
            end
            ST_PAT:
            begin
                tbl_req.pat_wr_en = 1'b1;
                state_next        = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the control state, totals and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            done_reg    <= 1'b0;
            correct_reg <= '0;
            wrong_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= state_reg == ST_PAT;
            if (state_reg == ST_PAT)
            begin
                if (miss)
                begin
                    wrong_reg <= (wrong_reg == '1) ? wrong_reg : wrong_reg + 1'b1;
                end
                else
                begin
                    correct_reg <= (correct_reg == '1) ? correct_reg : correct_reg + 1'b1;
                end
            end
        end
    end

    // Capture the transaction and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hidx_reg  <= branch_address[HIST_INDEX_BITS+1:2];
            taken_reg <= actual_taken;
        end
        if (state_reg == ST_HIST)
        begin
            hist_reg <= tbl_rsp.hist_rdata;
        end
        if (state_reg == ST_PAT)
        begin
            pred_reg <= pred;
            miss_reg <= miss;
        end
    end

    assign done            = done_reg;
    assign predicted_taken = pred_reg;
    assign mispredicted    = miss_reg;
    assign correct_total   = correct_reg;
    assign wrong_total     = wrong_reg;

endmodule

// ===== hw/rtl/tlbp_checker.sv =====
// Port-level checker for the two-level local branch predictor, bound to the top level.
// Depends on two_level_local_branch_predictor.
module tlbp_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // A taken transaction makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("busy low after a transaction was taken");

    // Each transaction yields its result strobe after the history and pattern states
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |-> ##3 done)
        else $error("result strobe missing three cycles after a transaction");

    // The result strobe is never shown while busy
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // Result strobes never come back to back
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe on two cycles in a row");

endmodule

bind two_level_local_branch_predictor tlbp_checker u_tlbp_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
